// ===== design/mmc_pkg.sv =====
package mmc_pkg;

  // Number of axes that take part in the calibration, and the number of axis slots on the ports.
  localparam int AXES            = 3;
  localparam int MAG_AXES        = 3;
  localparam int SCALE_FRAC_BITS = 12;

  localparam int SAMPLE_W = 16;
  localparam int OFF_W    = 17;
  localparam int SCALE_W  = 20;
  localparam int SPREAD_W = 16;
  localparam int TOTAL_W  = SPREAD_W + 2;
  localparam int DEN_W    = SPREAD_W + 2;
  localparam int NUM_W    = TOTAL_W + SCALE_FRAC_BITS + 1;
  localparam int CMP_W    = DEN_W + SCALE_W;
  localparam int CFG_W    = 16;
  localparam int AXIS_W   = 2;
  localparam int STEP_W   = $clog2(SCALE_W);

  localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1) << SCALE_FRAC_BITS;
  localparam logic [SCALE_W-1:0] SCALE_MAX = '1;
  localparam logic [CFG_W-1:0]   MIN_SPREAD_RST = CFG_W'(2);

  localparam logic OP_SEED   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_MIN_SPREAD = '0;

  typedef struct packed {
    logic              update;
    logic              spread;
    logic              total;
    logic              load;
    logic              prep;
    logic              step;
    logic              store;
    logic              load_out;
    logic [AXIS_W-1:0] axis;
  } mmc_cmd_t;

  typedef struct packed {
    logic small_spread;
  } mmc_sts_t;

endpackage

// ===== design/mag_minmax_calibrator_core.sv =====
// Min/max magnetometer calibrator. Each input beat carries one raw three-axis sample and an
// opcode: seed resets the per-axis minimum and maximum to the sample, update widens them (an
// update that arrives before any seed acts as a seed). Each input beat yields exactly one
// result beat with max + min per axis, which is twice the hard-iron offset, and a soft-iron
// scale per axis equal to the mean spread over the axes divided by that axis's spread, in
// unsigned Q8.12, rounded to nearest and saturated at the all-ones code. An axis whose spread
// does not exceed the min_spread register (byte address 0, reset value 2) gets a scale of
// exactly 1.0. Timing: a beat is taken only while the block is idle. An item goes through the
// min/max update and spread summing, then per axis a load and prepare step, the division for
// an axis that does not have a small spread, and a store, then a hand-over of the result to
// the output register. The division is done by the single restoring divider that produces one
// quotient bit per cycle and is shared by the three axes. The output register holds a
// finished result while the next item is already at work, so a slow consumer only stalls
// the block when a second result is ready.
module mag_minmax_calibrator_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_opcode,
  input  logic signed [mmc_pkg::SAMPLE_W-1:0] in_mag_x,
  input  logic signed [mmc_pkg::SAMPLE_W-1:0] in_mag_y,
  input  logic signed [mmc_pkg::SAMPLE_W-1:0] in_mag_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mmc_pkg::OFF_W-1:0]    out_offset2_x,
  output logic signed [mmc_pkg::OFF_W-1:0]    out_offset2_y,
  output logic signed [mmc_pkg::OFF_W-1:0]    out_offset2_z,
  output logic        [mmc_pkg::SCALE_W-1:0]  out_scale_x,
  output logic        [mmc_pkg::SCALE_W-1:0]  out_scale_y,
  output logic        [mmc_pkg::SCALE_W-1:0]  out_scale_z,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic        [mmc_pkg::PADDR_W-1:0]  paddr,
  input  logic        [mmc_pkg::PDATA_W-1:0]  pwdata,
  output logic        [mmc_pkg::PDATA_W-1:0]  prdata,
  output logic                                pready
);

  mmc_pkg::mmc_cmd_t cmd;
  mmc_pkg::mmc_sts_t sts;

  logic [mmc_pkg::CFG_W-1:0] min_spread_r;
  logic                      reg_hit;

  // The register file is a single word; the upper address bits select it.
  assign reg_hit = (paddr[mmc_pkg::PADDR_W-1:2] == mmc_pkg::REG_MIN_SPREAD);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_spread_r <= mmc_pkg::MIN_SPREAD_RST;
    end else if (psel && penable && pwrite && reg_hit) begin
      min_spread_r <= pwdata[mmc_pkg::CFG_W-1:0];
    end
  end

  assign prdata = reg_hit ? mmc_pkg::PDATA_W'(min_spread_r) : '0;

  // The controller sequences the update, spread, per-axis division and output load steps.
  mmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // The datapath holds the min/max state, the shared divider and the output register.
  mmc_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_opcode     (in_opcode),
    .in_mag_x      (in_mag_x),
    .in_mag_y      (in_mag_y),
    .in_mag_z      (in_mag_z),
    .min_spread    (min_spread_r),
    .out_offset2_x (out_offset2_x),
    .out_offset2_y (out_offset2_y),
    .out_offset2_z (out_offset2_z),
    .out_scale_x   (out_scale_x),
    .out_scale_y   (out_scale_y),
    .out_scale_z   (out_scale_z)
  );

endmodule

// ===== design/mmc_datapath.sv =====
module mmc_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mmc_pkg::mmc_cmd_t                   cmd,
  output mmc_pkg::mmc_sts_t                   sts,
  input  logic                                in_opcode,
  input  logic signed [mmc_pkg::SAMPLE_W-1:0] in_mag_x,
  input  logic signed [mmc_pkg::SAMPLE_W-1:0] in_mag_y,
  input  logic signed [mmc_pkg::SAMPLE_W-1:0] in_mag_z,
  input  logic        [mmc_pkg::CFG_W-1:0]    min_spread,
  output logic signed [mmc_pkg::OFF_W-1:0]    out_offset2_x,
  output logic signed [mmc_pkg::OFF_W-1:0]    out_offset2_y,
  output logic signed [mmc_pkg::OFF_W-1:0]    out_offset2_z,
  output logic        [mmc_pkg::SCALE_W-1:0]  out_scale_x,
  output logic        [mmc_pkg::SCALE_W-1:0]  out_scale_y,
  output logic        [mmc_pkg::SCALE_W-1:0]  out_scale_z
);

  logic signed [mmc_pkg::SAMPLE_W-1:0] sample [mmc_pkg::MAG_AXES];
  logic signed [mmc_pkg::SAMPLE_W-1:0] min_r  [mmc_pkg::MAG_AXES];
  logic signed [mmc_pkg::SAMPLE_W-1:0] max_r  [mmc_pkg::MAG_AXES];
  logic        [mmc_pkg::SPREAD_W-1:0] spread_r [mmc_pkg::MAG_AXES];
  logic signed [mmc_pkg::OFF_W-1:0]    off_r  [mmc_pkg::MAG_AXES];
  logic        [mmc_pkg::SCALE_W-1:0]  scale_r [mmc_pkg::MAG_AXES];
  logic signed [mmc_pkg::OFF_W-1:0]    out_off_r [mmc_pkg::MAG_AXES];
  logic        [mmc_pkg::SCALE_W-1:0]  out_scale_r [mmc_pkg::MAG_AXES];
  logic seeded_r;
  logic seed;

  logic [mmc_pkg::TOTAL_W-1:0] total_r, total_nxt;
  logic [mmc_pkg::DEN_W-1:0]   den_r, den_nxt;
  logic [mmc_pkg::NUM_W-1:0]   num_r, num_nxt;
  logic [mmc_pkg::DEN_W-1:0]   rem_r, rem_nxt;
  logic                        small_r, sat_r;
  logic [mmc_pkg::DEN_W:0]     shifted;
  logic                        step_ge;
  logic [mmc_pkg::SPREAD_W-1:0] load_spread;

  assign sample[0] = in_mag_x;
  assign sample[1] = in_mag_y;
  assign sample[2] = in_mag_z;

  assign seed = (in_opcode == mmc_pkg::OP_SEED) || !seeded_r;

  always_comb begin
    total_nxt = '0;
    for (int k = 0; k < mmc_pkg::AXES; k++) begin
      total_nxt = total_nxt + mmc_pkg::TOTAL_W'(spread_r[k]);
    end
  end

  // Denominator is the axis count times the spread of the selected axis; the numerator
  // carries half of it so that the truncating division rounds to nearest.
  assign load_spread = spread_r[cmd.axis];
  assign den_nxt = mmc_pkg::DEN_W'(mmc_pkg::DEN_W'(load_spread)
                                   * mmc_pkg::DEN_W'(mmc_pkg::AXES));
  assign num_nxt = {1'b0, total_r, {mmc_pkg::SCALE_FRAC_BITS{1'b0}}}
                   + mmc_pkg::NUM_W'(den_nxt >> 1);

  // One restoring division step: the low bits of num_r shift out numerator bits and
  // shift in quotient bits.
  assign shifted = {rem_r, num_r[mmc_pkg::SCALE_W-1]};
  assign step_ge = shifted >= {1'b0, den_r};
  assign rem_nxt = step_ge ? mmc_pkg::DEN_W'(shifted - {1'b0, den_r})
                           : shifted[mmc_pkg::DEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seeded_r <= 1'b0;
    end else if (cmd.update) begin
      seeded_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      for (int k = 0; k < mmc_pkg::AXES; k++) begin
        if (seed || sample[k] < min_r[k]) begin
          min_r[k] <= sample[k];
        end
        if (seed || sample[k] > max_r[k]) begin
          max_r[k] <= sample[k];
        end
      end
    end
    if (cmd.spread) begin
      for (int k = 0; k < mmc_pkg::AXES; k++) begin
        spread_r[k] <= mmc_pkg::SPREAD_W'({max_r[k][mmc_pkg::SAMPLE_W-1], max_r[k]}
                                          - {min_r[k][mmc_pkg::SAMPLE_W-1], min_r[k]});
        off_r[k]    <= {max_r[k][mmc_pkg::SAMPLE_W-1], max_r[k]}
                       + {min_r[k][mmc_pkg::SAMPLE_W-1], min_r[k]};
      end
    end
    if (cmd.total) begin
      total_r <= total_nxt;
    end
    if (cmd.load) begin
      den_r   <= den_nxt;
      num_r   <= num_nxt;
      small_r <= load_spread <= min_spread;
    end
    if (cmd.prep) begin
      sat_r <= mmc_pkg::CMP_W'(num_r) >= {den_r, {mmc_pkg::SCALE_W{1'b0}}};
      rem_r <= mmc_pkg::DEN_W'(num_r >> mmc_pkg::SCALE_W);
    end
    if (cmd.step) begin
      rem_r <= rem_nxt;
      num_r[mmc_pkg::SCALE_W-1:0] <= {num_r[mmc_pkg::SCALE_W-2:0], step_ge};
    end
    if (cmd.store) begin
      if (small_r) begin
        scale_r[cmd.axis] <= mmc_pkg::SCALE_ONE;
      end else if (sat_r) begin
        scale_r[cmd.axis] <= mmc_pkg::SCALE_MAX;
      end else begin
        scale_r[cmd.axis] <= num_r[mmc_pkg::SCALE_W-1:0];
      end
    end
    if (cmd.load_out) begin
      for (int k = 0; k < mmc_pkg::MAG_AXES; k++) begin
        if (k < mmc_pkg::AXES) begin
          out_off_r[k]   <= off_r[k];
          out_scale_r[k] <= scale_r[k];
        end else begin
          out_off_r[k]   <= '0;
          out_scale_r[k] <= '0;
        end
      end
    end
  end

  assign sts.small_spread = small_r;

  assign out_offset2_x = out_off_r[0];
  assign out_offset2_y = out_off_r[1];
  assign out_offset2_z = out_off_r[2];
  assign out_scale_x   = out_scale_r[0];
  assign out_scale_y   = out_scale_r[1];
  assign out_scale_z   = out_scale_r[2];

endmodule

// ===== design/mmc_ctrl.sv =====
module mmc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output mmc_pkg::mmc_cmd_t cmd,
  input  mmc_pkg::mmc_sts_t sts
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SPREAD = 3'd1;
  localparam logic [2:0] ST_TOTAL  = 3'd2;
  localparam logic [2:0] ST_LOAD   = 3'd3;
  localparam logic [2:0] ST_PREP   = 3'd4;
  localparam logic [2:0] ST_DIV    = 3'd5;
  localparam logic [2:0] ST_STORE  = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  logic [2:0]                   state_r, state_nxt;
  logic [mmc_pkg::AXIS_W-1:0]   axis_r, axis_nxt;
  logic [mmc_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic                         out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.axis      = axis_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.update = 1'b1;
          state_nxt  = ST_SPREAD;
        end
      end
      ST_SPREAD: begin
        cmd.spread = 1'b1;
        state_nxt  = ST_TOTAL;
      end
      ST_TOTAL: begin
        cmd.total = 1'b1;
        axis_nxt  = '0;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        if (sts.small_spread) begin
          state_nxt = ST_STORE;
        end else begin
          cmd.prep  = 1'b1;
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        step_nxt = step_r + 1'b1;
        if (step_r == mmc_pkg::STEP_W'(mmc_pkg::SCALE_W - 1)) begin
          state_nxt = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        if (axis_r == mmc_pkg::AXIS_W'(mmc_pkg::AXES - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      axis_r      <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== design/mmc_checker.sv =====
module mmc_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [mmc_pkg::OFF_W-1:0]    out_offset2_x,
  input logic        [mmc_pkg::SCALE_W-1:0]  out_scale_x
);

  // A result beat that is held back keeps its X-axis payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_offset2_x) && $stable(out_scale_x))
    else $error("result beat changed while stalled");

  // Reset leaves no result pending and the input side open.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset did not clear the handshake state");

  // An accepted sample keeps the block busy on the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a beat");

  // The X axis, which is active, never reports a zero scale.
  a_scale: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_scale_x != '0)
    else $error("zero scale on an active axis");

endmodule

bind mag_minmax_calibrator_core mmc_checker u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_offset2_x (out_offset2_x),
  .out_scale_x   (out_scale_x)
);

// ===== test/mag_minmax_calibrator_core_tb.sv =====
module mag_minmax_calibrator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The only register sits at byte address 0.
  localparam logic [mmc_pkg::PADDR_W-1:0] MIN_SPREAD_ADDR = {mmc_pkg::REG_MIN_SPREAD, 2'b00};
  // Receiver hold-off that is long enough for the block to fill up and stall its input.
  localparam int LONG_HOLD_CYCLES = 400;

  // One raw sample as it is offered on the input channel.
  typedef struct packed {
    logic        op;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
  } sample_t;

  // One calibration result, axis 0 is X.
  typedef struct packed {
    logic [2:0][mmc_pkg::OFF_W-1:0]   offset2;
    logic [2:0][mmc_pkg::SCALE_W-1:0] scale;
  } cal_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic                                in_opcode = mmc_pkg::OP_SEED;
  logic signed [mmc_pkg::SAMPLE_W-1:0] in_mag_x = '0;
  logic signed [mmc_pkg::SAMPLE_W-1:0] in_mag_y = '0;
  logic signed [mmc_pkg::SAMPLE_W-1:0] in_mag_z = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic signed [mmc_pkg::OFF_W-1:0]    out_offset2_x;
  logic signed [mmc_pkg::OFF_W-1:0]    out_offset2_y;
  logic signed [mmc_pkg::OFF_W-1:0]    out_offset2_z;
  logic        [mmc_pkg::SCALE_W-1:0]  out_scale_x;
  logic        [mmc_pkg::SCALE_W-1:0]  out_scale_y;
  logic        [mmc_pkg::SCALE_W-1:0]  out_scale_z;
  logic                                psel = 1'b0;
  logic                                penable = 1'b0;
  logic                                pwrite = 1'b0;
  logic        [mmc_pkg::PADDR_W-1:0]  paddr = '0;
  logic        [mmc_pkg::PDATA_W-1:0]  pwdata = '0;
  logic        [mmc_pkg::PDATA_W-1:0]  prdata;
  logic                                pready;

  mag_minmax_calibrator_core u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_mag_x      (in_mag_x),
    .in_mag_y      (in_mag_y),
    .in_mag_z      (in_mag_z),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_offset2_x (out_offset2_x),
    .out_offset2_y (out_offset2_y),
    .out_offset2_z (out_offset2_z),
    .out_scale_x   (out_scale_x),
    .out_scale_y   (out_scale_y),
    .out_scale_z   (out_scale_z),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk = ~clk;

  // Samples waiting to be offered, and calibrations predicted for accepted samples that
  // have not come out of the block yet.
  sample_t     pending_samples [$];
  cal_result_t due_calibrations [$];

  int   mismatch_count = 0;
  int   send_idle_pct = 29;
  int   recv_idle_pct = 69;
  logic in_taken = 1'b0;
  // Long hold-offs requested by the run control and the number the receiver has started.
  int   long_hold_reqs = 0;
  int   long_hold_started = 0;
  int   hold_left = 0;

  // Calibrator state as the testbench sees it. Reset is applied once, so the declaration
  // values are the reset values.
  logic signed [mmc_pkg::SAMPLE_W-1:0] cal_lo [3] = '{default: '0};
  logic signed [mmc_pkg::SAMPLE_W-1:0] cal_hi [3] = '{default: '0};
  logic                                cal_seeded = 1'b0;
  logic [mmc_pkg::CFG_W-1:0]           cal_min_spread = mmc_pkg::MIN_SPREAD_RST;

  // Center and swing of the readings per axis for the current random run. A small swing keeps
  // the spread near min_spread, a large one drives the scale of the other axes to saturation.
  int axis_center [3];
  int axis_swing [3];

  // Folds one accepted sample into the min/max state and works out the calibration that the
  // block has to return for it.
  function automatic cal_result_t calibrate_sample(logic op, logic [15:0] mx, logic [15:0] my,
                                                   logic [15:0] mz);
    logic signed [mmc_pkg::SAMPLE_W-1:0] smp [3];
    logic                                reseed;
    int                                  spread [3];
    longint unsigned                     spread_sum;
    longint unsigned                     num;
    longint unsigned                     den;
    longint unsigned                     quo;
    cal_result_t                         r;
    smp[0] = mx;
    smp[1] = my;
    smp[2] = mz;
    // An update that comes before any seed starts the calibration just as a seed does.
    reseed = (op == mmc_pkg::OP_SEED) || !cal_seeded;
    for (int k = 0; k < mmc_pkg::AXES && k < 3; k++) begin
      if (reseed) begin
        cal_lo[k] = smp[k];
        cal_hi[k] = smp[k];
      end else begin
        if (smp[k] < cal_lo[k]) cal_lo[k] = smp[k];
        if (smp[k] > cal_hi[k]) cal_hi[k] = smp[k];
      end
    end
    cal_seeded = 1'b1;

    spread_sum = 0;
    for (int k = 0; k < 3; k++) begin
      spread[k] = 0;
      if (k < mmc_pkg::AXES) begin
        spread[k] = int'(cal_hi[k]) - int'(cal_lo[k]);
        spread_sum += longint'(spread[k]);
      end
    end

    // Axes beyond AXES report zero in both fields.
    r = '0;
    for (int k = 0; k < 3; k++) begin
      if (k < mmc_pkg::AXES) begin
        r.offset2[k] = mmc_pkg::OFF_W'(int'(cal_hi[k]) + int'(cal_lo[k]));
        if (spread[k] > int'(cal_min_spread)) begin
          // Mean spread over this axis's spread, rounded to nearest with halves up.
          den = longint'(mmc_pkg::AXES) * longint'(spread[k]);
          num = spread_sum << mmc_pkg::SCALE_FRAC_BITS;
          quo = (num + den / 2) / den;
          if (quo > mmc_pkg::SCALE_MAX) quo = mmc_pkg::SCALE_MAX;
          r.scale[k] = quo[mmc_pkg::SCALE_W-1:0];
        end else begin
          r.scale[k] = mmc_pkg::SCALE_ONE;
        end
      end
    end
    return r;
  endfunction

  // Result side: predict on every accepted input beat, check every accepted output beat.
  // Both channels are sampled at the rising edge, before the block's own updates land.
  always @(posedge clk) begin : result_check
    cal_result_t want;
    cal_result_t got;
    in_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready)
        due_calibrations.push_back(calibrate_sample(in_opcode, in_mag_x, in_mag_y, in_mag_z));
      if (out_valid && out_ready) begin
        got.offset2[0] = out_offset2_x;
        got.offset2[1] = out_offset2_y;
        got.offset2[2] = out_offset2_z;
        got.scale[0]   = out_scale_x;
        got.scale[1]   = out_scale_y;
        got.scale[2]   = out_scale_z;
        if (due_calibrations.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: result beat expected none, actual offset2_x %0d scale_x %0d",
                   $time, out_offset2_x, out_scale_x);
        end else begin
          want = due_calibrations.pop_front();
          for (int k = 0; k < 3; k++) begin
            if (got.offset2[k] !== want.offset2[k]) begin
              mismatch_count++;
              $display("%0t ns: offset2 axis %0d expected %0d, actual %0d", $time, k,
                       $signed(want.offset2[k]), $signed(got.offset2[k]));
            end
            if (got.scale[k] !== want.scale[k]) begin
              mismatch_count++;
              $display("%0t ns: scale axis %0d expected %0d, actual %0d", $time, k,
                       want.scale[k], got.scale[k]);
            end
          end
        end
      end
    end
  end

  // Sample driver. A new beat goes out only once the previous one was taken; valid stays up
  // with a steady payload until then. Gaps come from send_idle_pct.
  always @(negedge clk) begin : sample_driver
    sample_t s;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s = pending_samples.pop_front();
        in_opcode <= s.op;
        in_mag_x  <= s.x;
        in_mag_y  <= s.y;
        in_mag_z  <= s.z;
        in_valid  <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver. It stalls at random, and on request holds off for a long stretch that
  // it counts down itself.
  always @(negedge clk) begin
    if (long_hold_started != long_hold_reqs) begin
      long_hold_started <= long_hold_reqs;
      hold_left         <= LONG_HOLD_CYCLES;
      out_ready         <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic queue_beat(logic op, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    sample_t s;
    s.op = op;
    s.x  = x;
    s.y  = y;
    s.z  = z;
    pending_samples.push_back(s);
  endtask

  // Mostly a reading around the current center, sometimes a full-range word or a rail value.
  function automatic logic [15:0] draw_reading(int center, int swing);
    int          v;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 6) return 16'($urandom);
    if (pick < 9) return pick[0] ? 16'h7FFF : 16'h8000;
    v = center + int'($urandom_range(2 * swing)) - swing;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  // Calibration runs: a seed followed by updates, with a new run now and then. A few runs
  // start with an update and a few stray seeds break a run early.
  task automatic queue_random_run(int n);
    logic op;
    for (int i = 0; i < n; i++) begin
      op = mmc_pkg::OP_UPDATE;
      if (i == 0 || $urandom_range(99) < 5) begin
        op = ($urandom_range(9) == 0) ? mmc_pkg::OP_UPDATE : mmc_pkg::OP_SEED;
        for (int k = 0; k < 3; k++) begin
          axis_center[k] = int'($urandom_range(60000)) - 30000;
          case ($urandom_range(3))
            0: axis_swing[k] = $urandom_range(3);
            1: axis_swing[k] = $urandom_range(200);
            2: axis_swing[k] = $urandom_range(4000);
            default: axis_swing[k] = $urandom_range(32767);
          endcase
        end
      end else if ($urandom_range(99) < 3) begin
        op = mmc_pkg::OP_SEED;
      end
      queue_beat(op, draw_reading(axis_center[0], axis_swing[0]),
                 draw_reading(axis_center[1], axis_swing[1]),
                 draw_reading(axis_center[2], axis_swing[2]));
    end
  endtask

  // Returns once every queued sample was taken and every predicted result has come out.
  // Checked on the falling edge so that it never races the rising-edge bookkeeping.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || due_calibrations.size() != 0);
  endtask

  // One register access: setup cycle, then access cycle until pready is seen at a rising edge.
  task automatic apb_xfer(logic wr, logic [mmc_pkg::PDATA_W-1:0] wdata,
                          output logic [mmc_pkg::PDATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= MIN_SPREAD_ADDR;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes min_spread while the block is idle, tracks it, and reads it back.
  task automatic set_min_spread(logic [mmc_pkg::CFG_W-1:0] value);
    logic [mmc_pkg::PDATA_W-1:0] rd;
    apb_xfer(1'b1, mmc_pkg::PDATA_W'(value), rd);
    cal_min_spread = value;
    apb_xfer(1'b0, '0, rd);
    if (rd !== mmc_pkg::PDATA_W'(value)) begin
      mismatch_count++;
      $display("%0t ns: min_spread read expected %0d, actual %0d", $time, value, rd);
    end
  endtask

  // Run control: reset, directed samples, then six random runs over three idling schedules.
  initial begin : stimulus
    logic [mmc_pkg::CFG_W-1:0] spread_floor [6];
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With the reset min_spread of 2. An update before any seed acts as a seed, then an axis
    // just above the floor; full-scale swings on all axes; one narrow axis against two full
    // ones, which saturates its scale; alternating bit patterns; a spread right at the floor.
    queue_beat(mmc_pkg::OP_UPDATE, 16'd100, -16'sd200, 16'd300);
    queue_beat(mmc_pkg::OP_UPDATE, 16'd101, -16'sd198, 16'd303);
    queue_beat(mmc_pkg::OP_SEED, 16'h7FFF, 16'h8000, 16'h0000);
    queue_beat(mmc_pkg::OP_UPDATE, 16'h8000, 16'h7FFF, 16'h0000);
    queue_beat(mmc_pkg::OP_UPDATE, 16'h0000, 16'h0000, 16'h8000);
    queue_beat(mmc_pkg::OP_UPDATE, 16'h0000, 16'h0000, 16'h7FFF);
    queue_beat(mmc_pkg::OP_SEED, 16'h8000, 16'h8000, 16'h8000);
    queue_beat(mmc_pkg::OP_UPDATE, -16'sd32765, 16'h7FFF, 16'h7FFF);
    queue_beat(mmc_pkg::OP_SEED, 16'h5555, 16'hAAAA, 16'h0F0F);
    queue_beat(mmc_pkg::OP_UPDATE, 16'hAAAA, 16'h5555, 16'hF0F0);
    queue_beat(mmc_pkg::OP_UPDATE, 16'hFFFF, 16'h0001, 16'h8001);
    queue_beat(mmc_pkg::OP_SEED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_beat(mmc_pkg::OP_UPDATE, 16'h0001, 16'h0001, 16'h0001);
    wait_drained();

    // Zero floor: a spread of one already gets a computed scale.
    set_min_spread('0);
    @(posedge clk);
    queue_beat(mmc_pkg::OP_SEED, 16'd7, 16'd7, 16'd7);
    queue_beat(mmc_pkg::OP_UPDATE, 16'd8, 16'd7, 16'd7);
    queue_beat(mmc_pkg::OP_UPDATE, 16'd8, 16'd100, -16'sd7);
    wait_drained();

    // Top floor: even a full-scale spread does not exceed it, so every scale is 1.0.
    set_min_spread('1);
    @(posedge clk);
    queue_beat(mmc_pkg::OP_SEED, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    queue_beat(mmc_pkg::OP_UPDATE, 16'h8000, 16'h8000, 16'h8000);
    wait_drained();

    spread_floor[0] = mmc_pkg::CFG_W'($urandom_range(500));
    spread_floor[1] = '0;
    spread_floor[2] = mmc_pkg::CFG_W'($urandom);
    spread_floor[3] = mmc_pkg::CFG_W'($urandom_range(50));
    spread_floor[4] = mmc_pkg::CFG_W'($urandom_range(3000));
    spread_floor[5] = mmc_pkg::MIN_SPREAD_RST;

    for (int run = 0; run < 6; run++) begin
      // Runs 0-1: slow receiver; runs 2-3: slow sender; runs 4-5: neither idles.
      case (run / 2)
        0: begin
          send_idle_pct = 29;
          recv_idle_pct = 69;
        end
        1: begin
          send_idle_pct = 69;
          recv_idle_pct = 29;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      set_min_spread(spread_floor[run]);
      @(posedge clk);
      queue_random_run(125);
      if (run == 5) begin
        // Hold the receiver off in the middle of a busy run while the sender keeps offering.
        while (pending_samples.size() > 60) @(negedge clk);
        @(posedge clk);
        long_hold_reqs++;
      end
      // The sender then pauses until the block has returned everything.
      wait_drained();
    end

    repeat (100) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Generous bound: several times the slowest legal run of about 800 samples.
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
